@@ sv/htd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the table-driven Huffman decoder.
// Used by htd_ctrl, htd_datapath and huffman_table_decoder_core; no dependencies.

package htd_pkg;

   // Sizing of the table, codes and the pending bit buffer.
   localparam int TABLE_DEPTH  = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int BYTE_W       = 8;
   localparam int MAX_RESULTS  = 8;

   // Fixed field widths of the ports.
   localparam int SYM_W         = 8;
   localparam int LEN_W         = 6;
   localparam int CODE_W        = 32;
   localparam int IDX_W         = 8;
   localparam int ENTRY_COUNT_W = 9;
   localparam int PAD_W         = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 9;

   // Derived widths.
   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int SCAN_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WIN_W   = MAX_CODE_LEN;
   localparam int BUF_W   = MAX_CODE_LEN + BYTE_W;
   localparam int BCNT_W  = $clog2(BUF_W + 1);
   localparam int SH_W    = $clog2(WIN_W + 1);
   localparam int RES_W   = $clog2(MAX_RESULTS + 1);
   localparam int ENTRY_W = SYM_W + LEN_W + CODE_W;
   localparam int CMP_W   = (BCNT_W > LEN_W) ? BCNT_W : LEN_W;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_BITS    = CSR_INDEX_W'(1);

   // Input item operations.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // write one table entry from the request beat
      logic append;      // append the data byte and restart the scan
      logic scan_step;   // advance the table scan by one entry
      logic consume;     // take the matched entry: drop its bits, hold its symbol
      logic emit_held;   // put the held symbol on the result ports
      logic emit_error;  // put an error result on the result ports
      logic emit_last;   // mark the result being put out as the last one
      logic clear_buf;   // empty the pending bit buffer
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;         // the entry under test matches the pending bits
      logic exhausted;   // the scan passed every entry without a match
      logic buf_empty;   // no pending bits
      logic err_cond;    // pending bits reach the longest usable code length
      logic last_in;     // the current data byte closes the stream
   } stat_type;

endpackage

@@ sv/htd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the Huffman decoder: sequences loads, table
// scans and result beats. Depends on htd_pkg.

module htd_ctrl import htd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_op,
   output logic     busy,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type          state_ff, state_in;
   logic [RES_W-1:0]   nres_ff, nres_in;
   logic               held_ff, held_in;
   logic               err_ff, err_in;

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nres_ff  <= '0;
         held_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         nres_ff  <= nres_in;
         held_ff  <= held_in;
         err_ff   <= err_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      nres_in  = nres_ff;
      held_in  = held_ff;
      err_in   = err_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.append = 1'b1;
                  nres_in    = '0;
                  held_in    = 1'b0;
                  err_in     = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Decoding stops once the buffer is empty or the result budget is spent.
            if (stat.buf_empty || (nres_ff == RES_W'(MAX_RESULTS))) begin
               err_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
               if (stat.hit) begin
                  // A new symbol releases the one held before it.
                  cmd.consume   = 1'b1;
                  cmd.emit_held = held_ff;
                  held_in       = 1'b1;
                  nres_in       = nres_ff + 1'b1;
               end else if (stat.exhausted) begin
                  err_in   = stat.err_cond;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (err_ff) begin
               if (held_ff) begin
                  cmd.emit_held = 1'b1;
                  held_in       = 1'b0;
               end else begin
                  cmd.emit_error = 1'b1;
                  cmd.emit_last  = 1'b1;
                  cmd.clear_buf  = 1'b1;
                  err_in         = 1'b0;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.emit_held = held_ff;
               cmd.emit_last = held_ff;
               cmd.clear_buf = stat.last_in;
               held_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/htd_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the Huffman decoder: code table memory, pending bit buffer,
// table scan with prefix match, configuration registers and result registers.
// Depends on htd_pkg.

module htd_datapath import htd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     csr_valid,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic [SYM_W-1:0]         req_entry_symbol,
   input  logic [LEN_W-1:0]         req_entry_length,
   input  logic [CODE_W-1:0]        req_entry_code,
   input  logic [BYTE_W-1:0]        req_data_byte,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   output logic [SYM_W-1:0]         rsp_symbol,
   output logic                     rsp_error,
   output logic                     rsp_last
);

   logic [ENTRY_W-1:0]        table_mem [TABLE_DEPTH];
   logic [ENTRY_COUNT_W-1:0]  entry_count_ff;
   logic [PAD_W-1:0]          pad_bits_ff;
   logic [BUF_W-1:0]          buf_ff, buf_in;
   logic [BCNT_W-1:0]         bcnt_ff, bcnt_in;
   logic                      in_last_ff;
   logic [SCAN_W-1:0]         scan_ff, scan_in, limit;
   logic                      rd_vld_ff, rd_vld_in, rd_en;
   logic [ENTRY_W-1:0]        rd_data_ff;
   logic [LEN_W-1:0]          longest_ff, longest_in;
   logic [SYM_W-1:0]          held_sym_ff;
   logic                      rsp_valid_ff;
   logic [SYM_W-1:0]          rsp_symbol_ff;
   logic                      rsp_error_ff, rsp_last_ff;

   logic [SYM_W-1:0]          rd_sym;
   logic [LEN_W-1:0]          rd_len;
   logic [CODE_W-1:0]         rd_code;
   logic                      usable, fits, match;
   logic [SH_W-1:0]           sh;
   logic [WIN_W-1:0]          win, code_al, mask;
   logic [BYTE_W-1:0]         keep, byte_m;
   logic [BCNT_W-1:0]         nbits;
   logic                      wr_in_range;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         pad_bits_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENTRY_COUNT: entry_count_ff <= csr_data[ENTRY_COUNT_W-1:0];
            CSR_PAD_BITS:    pad_bits_ff    <= csr_data[PAD_W-1:0];
            default:         ;
         endcase
      end
   end

   // Scan bound: the entry count, capped at the table depth.
   assign limit = (32'(entry_count_ff) < 32'(TABLE_DEPTH)) ?
                  SCAN_W'(entry_count_ff) : SCAN_W'(TABLE_DEPTH);
   assign rd_en = cmd.scan_step && (scan_ff < limit);
   assign wr_in_range = (32'(req_entry_index) < 32'(TABLE_DEPTH));

   // Code table: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (cmd.load && wr_in_range) begin
         table_mem[ADDR_W'(req_entry_index)] <=
            {req_entry_symbol, req_entry_length, req_entry_code};
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[scan_ff[ADDR_W-1:0]];
      end
   end

   assign rd_sym  = rd_data_ff[ENTRY_W-1 -: SYM_W];
   assign rd_len  = rd_data_ff[CODE_W +: LEN_W];
   assign rd_code = rd_data_ff[CODE_W-1:0];

   // Prefix match: align the code under the top of the buffer and compare the
   // first rd_len bits only.
   assign usable  = (rd_len != '0) && (32'(rd_len) <= 32'(MAX_CODE_LEN));
   assign fits    = (CMP_W'(rd_len) <= CMP_W'(bcnt_ff));
   assign sh      = SH_W'(WIN_W) - SH_W'(rd_len);
   assign win     = buf_ff[BUF_W-1 -: WIN_W];
   assign code_al = WIN_W'(rd_code) << sh;
   assign mask    = {WIN_W{1'b1}} << sh;
   assign match   = (((win ^ code_al) & mask) == '0);

   // Incoming byte: drop the padding bits of the final byte.
   assign keep   = req_last_byte ? ({BYTE_W{1'b1}} << pad_bits_ff) : {BYTE_W{1'b1}};
   assign byte_m = req_data_byte & keep;
   assign nbits  = BCNT_W'(BYTE_W) - (req_last_byte ? BCNT_W'(pad_bits_ff) : '0);

   // Next values of the buffer and the scan.
   always_comb begin
      buf_in     = buf_ff;
      bcnt_in    = bcnt_ff;
      scan_in    = scan_ff;
      rd_vld_in  = rd_vld_ff;
      longest_in = longest_ff;
      if (cmd.scan_step) begin
         rd_vld_in = rd_en;
         if (rd_en) begin
            scan_in = scan_ff + 1'b1;
         end
         if (rd_vld_ff && usable && (rd_len > longest_ff)) begin
            longest_in = rd_len;
         end
      end
      if (cmd.append) begin
         // Bits below the count are kept zero, so the new bits are ORed in.
         buf_in     = buf_ff | ({byte_m, {(BUF_W-BYTE_W){1'b0}}} >> bcnt_ff);
         bcnt_in    = bcnt_ff + nbits;
         scan_in    = '0;
         rd_vld_in  = 1'b0;
         longest_in = '0;
      end
      if (cmd.consume) begin
         buf_in     = buf_ff << rd_len;
         bcnt_in    = bcnt_ff - BCNT_W'(rd_len);
         scan_in    = '0;
         rd_vld_in  = 1'b0;
         longest_in = '0;
      end
      if (cmd.clear_buf) begin
         buf_in  = '0;
         bcnt_in = '0;
      end
   end

   // Buffer, scan and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         bcnt_ff      <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         longest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         bcnt_ff      <= bcnt_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         longest_ff   <= longest_in;
         rsp_valid_ff <= cmd.emit_held | cmd.emit_error;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         in_last_ff <= req_last_byte;
      end
      if (cmd.consume) begin
         held_sym_ff <= rd_sym;
      end
      rsp_symbol_ff <= cmd.emit_error ? '0 : held_sym_ff;
      rsp_error_ff  <= cmd.emit_error;
      rsp_last_ff   <= cmd.emit_last;
   end

   // Status towards the controller.
   always_comb begin
      stat.hit       = rd_vld_ff && usable && fits && match;
      stat.exhausted = !rd_vld_ff && !(scan_ff < limit);
      stat.buf_empty = (bcnt_ff == '0);
      stat.err_cond  = (CMP_W'(bcnt_ff) >= CMP_W'(longest_ff));
      stat.last_in   = in_last_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_error  = rsp_error_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ sv/huffman_table_decoder_core.sv @@
`timescale 1ns / 1ps
// Top level of the table-driven Huffman decoder: joins controller and datapath.
// Depends on htd_pkg, htd_ctrl and htd_datapath.
//
// Usage. A request beat is taken when start is high and busy is low. With
// req_op low it writes one code table entry (symbol, length, code) while
// busy stays low. With req_op high it appends req_data_byte, most
// significant bit first, to the pending bits and decodes them. The table is
// scanned from entry 0, one entry per cycle through its single read port; the
// first entry whose code is a prefix of the pending bits gives a symbol, and
// the scan restarts. Up to eight results per byte leave on rsp_valid, one
// beat per cycle; rsp_last marks the final beat of the byte. When no entry
// matches and the pending bits reach the longest usable code, an error beat
// ends the byte and the buffer is emptied.
// Result beats cannot be held off by the receiver; they are registered and
// appear in the cycle after they are decided. Configuration is written over
// csr_valid/csr_ready (always ready); the user must write it only while busy
// is low, which the block itself does not enforce. Reset empties the pending
// bits and clears both registers; the table holds nothing usable until it is
// loaded, and no clearing pass is run.

module huffman_table_decoder_core import htd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic [SYM_W-1:0]        req_entry_symbol,
   input  logic [LEN_W-1:0]        req_entry_length,
   input  logic [CODE_W-1:0]       req_entry_code,
   input  logic [BYTE_W-1:0]       req_data_byte,
   input  logic                    req_last_byte,
   output logic                    rsp_valid,
   output logic [SYM_W-1:0]        rsp_symbol,
   output logic                    rsp_error,
   output logic                    rsp_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   htd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .busy   (busy),
      .cmd    (cmd),
      .stat   (stat)
   );

   htd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_valid        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_entry_index  (req_entry_index),
      .req_entry_symbol (req_entry_symbol),
      .req_entry_length (req_entry_length),
      .req_entry_code   (req_entry_code),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

   // A result beat is only ever decided while a byte is being worked on.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a byte in progress");

   // The last beat of a byte finds the block ready for the next request.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy after the last result beat");

   // A table load completes in its own cycle.
   a_load_single: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_LOAD)) |=> (!busy && !rsp_valid))
      else $error("table load left the block busy or produced a result");

   // An error beat carries a zero symbol and closes the byte.
   a_err_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> ((rsp_symbol == '0) && rsp_last))
      else $error("error beat with a symbol or not closing the byte");

endmodule
